@@ sv/tcc_pkg.sv @@
// Shared types and constants for the text console cursor engine.
`default_nettype none

package tcc_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 32;

    localparam int COLUMNS_DEF = 100;
    localparam int ROWS_DEF = 37;

    // Result queue depth, in requests that cause at least one result
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ACT_DRAW   = 2'd0,
        ACT_SCROLL = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // First result of a request; a scroll may follow it
    typedef struct packed {
        action_t            action;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               scroll_after;
    } entry_t;

    typedef struct packed {
        logic             has_result;
        entry_t           entry;
        logic [COL_W-1:0] col_next;
        logic [ROW_W-1:0] row_next;
    } step_t;

endpackage

`default_nettype wire

@@ sv/tcc_step.sv @@
// Cursor update and result generation for one request.
`default_nettype none

module tcc_step #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
    input  wire logic                         command,
    input  wire logic [tcc_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tcc_pkg::COLOR_W-1:0]  fg_color,
    input  wire logic [tcc_pkg::COLOR_W-1:0]  bg_color,
    input  wire logic [tcc_pkg::COL_W-1:0]    cur_col,
    input  wire logic [tcc_pkg::ROW_W-1:0]    cur_row,
    output tcc_pkg::step_t                    step
);

    localparam logic [tcc_pkg::COL_W:0]   COLS_LIM = (tcc_pkg::COL_W + 1)'(COLUMNS);
    localparam logic [tcc_pkg::ROW_W-1:0] LAST_ROW = tcc_pkg::ROW_W'(ROWS - 1);

    logic [tcc_pkg::COL_W:0]   col_inc;
    logic [tcc_pkg::COL_W:0]   col_tab;
    logic                      at_last_row;
    logic [tcc_pkg::ROW_W-1:0] row_nl;

    assign col_inc = {1'b0, cur_col} + (tcc_pkg::COL_W + 1)'(1);
    // advance to the next multiple of four above the column
    assign col_tab = ({1'b0, cur_col} + (tcc_pkg::COL_W + 1)'(4))
                     & ~(tcc_pkg::COL_W + 1)'(3);
    assign at_last_row = (cur_row == LAST_ROW);
    assign row_nl = at_last_row ? LAST_ROW : cur_row + tcc_pkg::ROW_W'(1);

    always_comb begin
        step = '0;
        step.col_next = cur_col;
        step.row_next = cur_row;
        step.entry.action = tcc_pkg::ACT_DRAW;
        if (command == tcc_pkg::CMD_CLEAR) begin
            step.col_next = '0;
            step.row_next = '0;
            step.has_result = 1'b1;
            step.entry.action = tcc_pkg::ACT_CLEAR;
        end else begin
            case (char_code)
                tcc_pkg::CH_CR: begin
                    step.col_next = '0;
                end
                tcc_pkg::CH_LF: begin
                    step.col_next = '0;
                    step.row_next = row_nl;
                    step.has_result = at_last_row;
                    step.entry.action = tcc_pkg::ACT_SCROLL;
                end
                tcc_pkg::CH_BS: begin
                    if (cur_col != '0) begin
                        step.col_next = cur_col - tcc_pkg::COL_W'(1);
                        step.has_result = 1'b1;
                        step.entry.col = cur_col - tcc_pkg::COL_W'(1);
                        step.entry.row = cur_row;
                        step.entry.glyph = tcc_pkg::CH_SPACE;
                        step.entry.fg = fg_color;
                        step.entry.bg = bg_color;
                    end
                end
                tcc_pkg::CH_TAB: begin
                    if (col_tab >= COLS_LIM) begin
                        step.col_next = '0;
                        step.row_next = row_nl;
                        step.has_result = at_last_row;
                        step.entry.action = tcc_pkg::ACT_SCROLL;
                    end else begin
                        step.col_next = col_tab[tcc_pkg::COL_W-1:0];
                    end
                end
                default: begin
                    step.has_result = 1'b1;
                    step.entry.col = cur_col;
                    step.entry.row = cur_row;
                    step.entry.glyph = char_code;
                    step.entry.fg = fg_color;
                    step.entry.bg = bg_color;
                    if (col_inc >= COLS_LIM) begin
                        step.col_next = '0;
                        step.row_next = row_nl;
                        step.entry.scroll_after = at_last_row;
                    end else begin
                        step.col_next = col_inc[tcc_pkg::COL_W-1:0];
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/tcc_queue.sv @@
// Result queue: one entry per request, split into one or two output beats.
`default_nettype none

module tcc_queue (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire tcc_pkg::entry_t              push_entry,
    output logic                              room,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_action,
    output logic [tcc_pkg::COL_W-1:0]         m_cell_col,
    output logic [tcc_pkg::ROW_W-1:0]         m_cell_row,
    output logic [tcc_pkg::CHAR_W-1:0]        m_glyph_code,
    output logic [tcc_pkg::COLOR_W-1:0]       m_draw_fg,
    output logic [tcc_pkg::COLOR_W-1:0]       m_draw_bg,
    output logic                              m_last_of_run
);

    tcc_pkg::entry_t entry_reg [tcc_pkg::Q_DEPTH];

    logic [tcc_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tcc_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tcc_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                        beat_reg, beat_next;

    tcc_pkg::entry_t head;
    logic            out_fire;
    logic            pop;

    assign head = entry_reg[rd_ptr_reg];
    assign room = (count_reg != tcc_pkg::Q_CNT_W'(tcc_pkg::Q_DEPTH));
    assign m_valid = (count_reg != '0);
    assign out_fire = m_valid && m_ready;
    assign pop = out_fire && m_last_of_run;

    // second beat of an entry is the trailing scroll, fields zero
    always_comb begin
        if (beat_reg) begin
            m_action = tcc_pkg::ACT_SCROLL;
            m_cell_col = '0;
            m_cell_row = '0;
            m_glyph_code = '0;
            m_draw_fg = '0;
            m_draw_bg = '0;
            m_last_of_run = 1'b1;
        end else begin
            m_action = head.action;
            m_cell_col = head.col;
            m_cell_row = head.row;
            m_glyph_code = head.glyph;
            m_draw_fg = head.fg;
            m_draw_bg = head.bg;
            m_last_of_run = !head.scroll_after;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        beat_next = beat_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + tcc_pkg::Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + tcc_pkg::Q_PTR_W'(1);
            beat_next = 1'b0;
        end else if (out_fire) begin
            beat_next = 1'b1;
        end
        case ({push, pop})
            2'b10: count_next = count_reg + tcc_pkg::Q_CNT_W'(1);
            2'b01: count_next = count_reg - tcc_pkg::Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            beat_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tcc_pkg::Q_CNT_W'(tcc_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("push into full queue");

    a_beat_has_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_reg |-> (m_valid && head.scroll_after))
        else $error("second beat without pending scroll");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - tcc_pkg::Q_CNT_W'(1)))
        else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

@@ sv/text_console_cursor_engine.sv @@
// Text console cursor engine top level: request register, cursor state, result queue.
//
// Usage:
//   Requests arrive on the s_ channel (valid/ready): a put-character or a
//   clear-screen command with draw colors. Results leave on the m_ channel:
//   draw cell, scroll one line, or clear screen, with m_last_of_run marking
//   the final result of each request. A request causes zero, one or two
//   results; CR, LF without scroll, TAB without scroll and BS at column 0
//   cause none.
//   Path: a request is held in the request register and then written as a
//   result queue entry before its first result shows.
//   Throughput: one request per cycle while the result queue has room;
//   the output moves one result per cycle while m_ready is high, so a
//   wrapping character that also scrolls sends a draw, then a scroll. The
//   four-entry result queue sets how far input runs ahead of the receiver.
//   Reset (aresetn low, synchronous) homes the cursor to column 0, row 0
//   and empties the request register and result queue.
//   When m_ready stays low the queue fills, the request register then
//   holds, and s_ready drops; nothing is lost or reordered.
`default_nettype none

module text_console_cursor_engine #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic [tcc_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic [tcc_pkg::COLOR_W-1:0]  s_fg_color,
    input  wire logic [tcc_pkg::COLOR_W-1:0]  s_bg_color,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_action,
    output logic [tcc_pkg::COL_W-1:0]         m_cell_col,
    output logic [tcc_pkg::ROW_W-1:0]         m_cell_row,
    output logic [tcc_pkg::CHAR_W-1:0]        m_glyph_code,
    output logic [tcc_pkg::COLOR_W-1:0]       m_draw_fg,
    output logic [tcc_pkg::COLOR_W-1:0]       m_draw_bg,
    output logic                              m_last_of_run
);

    logic                          req_valid_reg;
    logic                          cmd_reg;
    logic [tcc_pkg::CHAR_W-1:0]    char_reg;
    logic [tcc_pkg::COLOR_W-1:0]   fg_reg;
    logic [tcc_pkg::COLOR_W-1:0]   bg_reg;
    logic [tcc_pkg::COL_W-1:0]     col_reg;
    logic [tcc_pkg::ROW_W-1:0]     row_reg;

    tcc_pkg::step_t step;
    logic           q_room;
    logic           consume;
    logic           push;

    tcc_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .command   (cmd_reg),
        .char_code (char_reg),
        .fg_color  (fg_reg),
        .bg_color  (bg_reg),
        .cur_col   (col_reg),
        .cur_row   (row_reg),
        .step      (step)
    );

    // a request with no result retires even when the queue is full
    assign consume = req_valid_reg && (!step.has_result || q_room);
    assign push = consume && step.has_result;
    assign s_ready = !req_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (consume) begin
                col_reg <= step.col_next;
                row_reg <= step.row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            char_reg <= s_char_code;
            fg_reg <= s_fg_color;
            bg_reg <= s_bg_color;
        end
    end

    tcc_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .push_entry    (step.entry),
        .room          (q_room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_cell_col    (m_cell_col),
        .m_cell_row    (m_cell_row),
        .m_glyph_code  (m_glyph_code),
        .m_draw_fg     (m_draw_fg),
        .m_draw_bg     (m_draw_bg),
        .m_last_of_run (m_last_of_run)
    );

`ifndef NO_ASSERTIONS
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < (tcc_pkg::COL_W + 1)'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < (tcc_pkg::ROW_W + 1)'(ROWS))
        else $error("cursor row out of range");

    a_clear_homes: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && cmd_reg == tcc_pkg::CMD_CLEAR) |=> (col_reg == '0 && row_reg == '0))
        else $error("clear did not home cursor");
`endif

endmodule

`default_nettype wire

@@ test/text_console_cursor_engine_tb.sv @@
// Testbench for the text console cursor engine: cursor prediction, checks on every result.
module text_console_cursor_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = tcc_pkg::COLUMNS_DEF;
    localparam int ROWS    = tcc_pkg::ROWS_DEF;
    localparam int RANDOM_ITEMS = 1080;

    typedef struct {
        tcc_pkg::action_t                     action;
        logic [tcc_pkg::COL_W-1:0]            col;
        logic [tcc_pkg::ROW_W-1:0]            row;
        logic [tcc_pkg::CHAR_W-1:0]           glyph;
        logic [tcc_pkg::COLOR_W-1:0]          fg;
        logic [tcc_pkg::COLOR_W-1:0]          bg;
        logic                                 last;
    } cell_action_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_command = tcc_pkg::CMD_PUT;
    logic [tcc_pkg::CHAR_W-1:0]   s_char_code = '0;
    logic [tcc_pkg::COLOR_W-1:0]  s_fg_color = '0;
    logic [tcc_pkg::COLOR_W-1:0]  s_bg_color = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_action;
    logic [tcc_pkg::COL_W-1:0]    m_cell_col;
    logic [tcc_pkg::ROW_W-1:0]    m_cell_row;
    logic [tcc_pkg::CHAR_W-1:0]   m_glyph_code;
    logic [tcc_pkg::COLOR_W-1:0]  m_draw_fg;
    logic [tcc_pkg::COLOR_W-1:0]  m_draw_bg;
    logic                         m_last_of_run;

    cell_action_t pending_actions[$];
    int unsigned  cursor_x = 0;
    int unsigned  cursor_y = 0;
    int           error_count = 0;
    int           burst_left = 0;
    int           rx_mode = 0;
    int           rx_left = 0;
    int           rx_phase = 0;

    text_console_cursor_engine #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_char_code(s_char_code),
        .s_fg_color(s_fg_color),
        .s_bg_color(s_bg_color),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_action(m_action),
        .m_cell_col(m_cell_col),
        .m_cell_row(m_cell_row),
        .m_glyph_code(m_glyph_code),
        .m_draw_fg(m_draw_fg),
        .m_draw_bg(m_draw_bg),
        .m_last_of_run(m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic cell_action_t make_action(tcc_pkg::action_t act, int unsigned col,
                                                 int unsigned row,
                                                 logic [tcc_pkg::CHAR_W-1:0] glyph,
                                                 logic [tcc_pkg::COLOR_W-1:0] fg,
                                                 logic [tcc_pkg::COLOR_W-1:0] bg);
        cell_action_t r;
        r.action = act;
        r.col    = col[tcc_pkg::COL_W-1:0];
        r.row    = row[tcc_pkg::ROW_W-1:0];
        r.glyph  = glyph;
        r.fg     = fg;
        r.bg     = bg;
        r.last   = 1'b0;
        return r;
    endfunction

    // Column 0 of the next row; returns 1 when the screen has to scroll
    function automatic bit advance_row();
        cursor_x = 0;
        cursor_y++;
        if (cursor_y >= ROWS) begin
            cursor_y = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_console_step(logic cmd, logic [tcc_pkg::CHAR_W-1:0] ch,
                                                 logic [tcc_pkg::COLOR_W-1:0] fg,
                                                 logic [tcc_pkg::COLOR_W-1:0] bg);
        cell_action_t step_out[$];
        if (cmd == tcc_pkg::CMD_CLEAR) begin
            cursor_x = 0;
            cursor_y = 0;
            step_out.push_back(make_action(tcc_pkg::ACT_CLEAR, 0, 0, '0, '0, '0));
        end else if (ch == tcc_pkg::CH_CR) begin
            cursor_x = 0;
        end else if (ch == tcc_pkg::CH_LF) begin
            if (advance_row())
                step_out.push_back(make_action(tcc_pkg::ACT_SCROLL, 0, 0, '0, '0, '0));
        end else if (ch == tcc_pkg::CH_BS) begin
            if (cursor_x > 0) begin
                cursor_x--;
                step_out.push_back(make_action(tcc_pkg::ACT_DRAW, cursor_x, cursor_y,
                                               tcc_pkg::CH_SPACE, fg, bg));
            end
        end else if (ch == tcc_pkg::CH_TAB) begin
            cursor_x = (cursor_x + 4) & ~32'd3;
            if (cursor_x >= COLUMNS) begin
                if (advance_row())
                    step_out.push_back(make_action(tcc_pkg::ACT_SCROLL, 0, 0, '0, '0, '0));
            end
        end else begin
            step_out.push_back(make_action(tcc_pkg::ACT_DRAW, cursor_x, cursor_y, ch, fg, bg));
            cursor_x++;
            if (cursor_x >= COLUMNS) begin
                if (advance_row())
                    step_out.push_back(make_action(tcc_pkg::ACT_SCROLL, 0, 0, '0, '0, '0));
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i])
            pending_actions.push_back(step_out[i]);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(logic cmd, logic [tcc_pkg::CHAR_W-1:0] ch,
                                logic [tcc_pkg::COLOR_W-1:0] fg,
                                logic [tcc_pkg::COLOR_W-1:0] bg);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_char_code <= ch;
        s_fg_color  <= fg;
        s_bg_color  <= bg;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_console_step(cmd, ch, fg, bg);
        burst_left--;
    endtask

    // Hold off new requests until every predicted result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_actions.size() != 0);
    endtask

    task automatic put_char(logic [tcc_pkg::CHAR_W-1:0] ch);
        send_request(tcc_pkg::CMD_PUT, ch, $urandom(), $urandom());
    endtask

    task automatic test_control_codes();
        send_request(tcc_pkg::CMD_PUT, "A", 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(tcc_pkg::CMD_PUT, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(tcc_pkg::CMD_PUT, 8'hFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(tcc_pkg::CMD_PUT, tcc_pkg::CH_BS, 32'h1234_5678, 32'h9ABC_DEF0);
        put_char(tcc_pkg::CH_CR);
        put_char(tcc_pkg::CH_BS);   // column zero: nothing to erase
        put_char(tcc_pkg::CH_TAB);
        put_char(tcc_pkg::CH_TAB);
        put_char(tcc_pkg::CH_BS);
        put_char(tcc_pkg::CH_TAB);  // one step back onto a tab stop
        put_char(tcc_pkg::CH_LF);
        put_char(tcc_pkg::CH_SPACE);
        send_request(tcc_pkg::CMD_CLEAR, "Z", 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(tcc_pkg::CMD_CLEAR, tcc_pkg::CH_LF, $urandom(), $urandom());
        put_char(8'h7F);
        wait_drained();
    endtask

    task automatic test_right_edge_wrap();
        put_char(tcc_pkg::CH_CR);
        repeat (COLUMNS / 4 - 1) put_char(tcc_pkg::CH_TAB);
        put_char("x");
        put_char("y");
        put_char("z");
        put_char("!");              // last column, wraps
        repeat (COLUMNS / 4 - 1) put_char(tcc_pkg::CH_TAB);
        put_char(tcc_pkg::CH_BS);
        put_char(tcc_pkg::CH_TAB);
        put_char(tcc_pkg::CH_TAB);  // tab past the edge wraps
        repeat (COLUMNS / 4 - 1) put_char(tcc_pkg::CH_TAB);
        put_char("a");
        put_char(tcc_pkg::CH_TAB);
        repeat (COLUMNS / 4) put_char(tcc_pkg::CH_TAB);
        wait_drained();
    endtask

    task automatic test_bottom_scroll();
        send_request(tcc_pkg::CMD_CLEAR, tcc_pkg::CHAR_W'($urandom()), $urandom(), $urandom());
        repeat (ROWS - 1) put_char(tcc_pkg::CH_LF);
        put_char(tcc_pkg::CH_LF);   // scroll, row stays on the last line
        put_char("q");
        put_char(tcc_pkg::CH_CR);
        repeat (COLUMNS / 4 - 1) put_char(tcc_pkg::CH_TAB);
        repeat (4) put_char(tcc_pkg::CHAR_W'($urandom_range(32, 126)));   // draw then scroll
        repeat (COLUMNS / 4) put_char(tcc_pkg::CH_TAB);                   // tab wrap scroll
        put_char(tcc_pkg::CH_BS);
        put_char("w");
        put_char(tcc_pkg::CH_BS);
        send_request(tcc_pkg::CMD_CLEAR, tcc_pkg::CH_TAB, $urandom(), $urandom());
        wait_drained();
    endtask

    task automatic test_random_traffic(int n_items);
        int run_left;
        int profile;
        int pick;
        int th[4];
        logic [tcc_pkg::CHAR_W-1:0] ch;
        run_left = 0;
        profile = 0;
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                profile  = $urandom_range(0, 3);
                run_left = $urandom_range(10, 120);
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
                if ($urandom_range(0, 5) == 0)
                    send_request(tcc_pkg::CMD_CLEAR, tcc_pkg::CHAR_W'($urandom()),
                                 $urandom(), $urandom());
            end
            run_left--;
            // thresholds: backspace, tab, newline, return; the rest is text
            case (profile)
                0:       th = '{5, 10, 13, 15};     // mostly text, wraps often
                1:       th = '{5, 10, 45, 55};     // newline heavy, reaches the bottom
                2:       th = '{10, 50, 55, 58};    // tab heavy
                default: th = '{40, 45, 50, 52};    // backspace heavy
            endcase
            pick = $urandom_range(0, 99);
            if (pick < th[0])
                ch = tcc_pkg::CH_BS;
            else if (pick < th[1])
                ch = tcc_pkg::CH_TAB;
            else if (pick < th[2])
                ch = tcc_pkg::CH_LF;
            else if (pick < th[3])
                ch = tcc_pkg::CH_CR;
            else
                ch = tcc_pkg::CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 199) == 0)
                send_request(tcc_pkg::CMD_CLEAR, ch, $urandom(), $urandom());
            else
                send_request(tcc_pkg::CMD_PUT, ch, $urandom(), $urandom());
        end
    endtask

    // Receiver: switches between steady, random, sparse and periodic stalls
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ((rx_phase % 16) >= 12);
        endcase
    end

    always @(posedge aclk) begin : check_results
        cell_action_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_actions.size() == 0) begin
                report_mismatch("unexpected result, action", m_action, 0);
            end else begin
                want = pending_actions.pop_front();
                if (m_action !== want.action)
                    report_mismatch("action", m_action, want.action);
                if (m_cell_col !== want.col)
                    report_mismatch("cell_col", m_cell_col, want.col);
                if (m_cell_row !== want.row)
                    report_mismatch("cell_row", m_cell_row, want.row);
                if (m_glyph_code !== want.glyph)
                    report_mismatch("glyph_code", m_glyph_code, want.glyph);
                if (m_draw_fg !== want.fg)
                    report_mismatch("draw_fg", m_draw_fg, want.fg);
                if (m_draw_bg !== want.bg)
                    report_mismatch("draw_bg", m_draw_bg, want.bg);
                if (m_last_of_run !== want.last)
                    report_mismatch("last_of_run", m_last_of_run, want.last);
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_control_codes();
        test_right_edge_wrap();
        test_bottom_scroll();
        test_random_traffic(RANDOM_ITEMS);
        s_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT: %0d results still expected", pending_actions.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
